/* rtl/ufsf_pkg.sv */
`default_nettype none
package ufsf_pkg;

    localparam int NODES   = 1024;
    localparam int IDX_W   = $clog2(NODES);
    localparam int FIELD_W = 10;
    localparam int COUNT_W = 10;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
        idx_t wr_data;
    } ufsf_mem_req_t;

endpackage
`default_nettype wire

/* rtl/ufsf_ifs.sv */
`default_nettype none
interface ufsf_edge_if import ufsf_pkg::*;;
    logic   valid;
    logic   ready;
    field_t node_a;
    field_t node_b;

    modport source (output valid, output node_a, output node_b, input ready);
    modport sink   (input valid, input node_a, input node_b, output ready);
endinterface

interface ufsf_result_if import ufsf_pkg::*;;
    logic   valid;
    logic   ready;
    logic   accepted;
    count_t forest_edges;

    modport source (output valid, output accepted, output forest_edges, input ready);
    modport sink   (input valid, input accepted, input forest_edges, output ready);
endinterface
`default_nettype wire

/* rtl/ufsf_parent_mem.sv */
`default_nettype none
module ufsf_parent_mem
    import ufsf_pkg::*;
(
    input  wire                clk,
    input  wire ufsf_mem_req_t req,
    output idx_t               rd_data
);

    idx_t mem [NODES];

    // read returns the old entry when the same address is written
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/union_find_spanning_forest.sv */
`default_nettype none
// union-find spanning forest
// edges (sink): one graph edge per transfer, node_a and node_b
// result (source): one transfer per edge, accepted and the running forest_edges
// the parent table sits in a single-port-read, single-port-write memory with
// a registered read; each find walks parent pointers one read per cycle,
// then a second pass rewrites every node on the path to point at the root
// per edge: the transfer, a find for each endpoint (no second pass when the
// endpoint is itself a root), then the link; the result register loads at
// the link and is shown on the next cycle
// an edge with an endpoint not below NODES skips the finds: transfer, then link
// after reset the block rewrites every entry of the parent table so every
// node is its own root; edges.ready stays low during that pass
// the result sits in an output register: if the receiver stalls, the next edge
// is still taken and worked on, and holds at its link step until the register
// frees up
module union_find_spanning_forest
    import ufsf_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    ufsf_edge_if.sink      edges,
    ufsf_result_if.source  result
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK,
        S_COMP_RD,
        S_COMP,
        S_LINK
    } state_t;

    state_t        state_reg;
    idx_t          clr_reg;
    idx_t          node_a_reg;
    idx_t          node_b_reg;
    logic          skip_reg;
    logic          side_reg;
    idx_t          cur_reg;
    idx_t          root_reg;
    idx_t          root_a_reg;
    count_t        count_reg;
    logic          out_valid_reg;
    logic          out_acc_reg;
    count_t        out_count_reg;

    ufsf_mem_req_t mem_req;
    idx_t          rd_data;
    idx_t          node_sel;
    logic          in_range;
    logic          can_load;
    logic          link_ok;
    logic          out_load;

    ufsf_parent_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign node_sel = side_reg ? node_b_reg : node_a_reg;
    assign in_range = (32'(edges.node_a) < NODES) && (32'(edges.node_b) < NODES);
    assign can_load = !out_valid_reg || result.ready;
    assign link_ok  = !skip_reg && (root_a_reg != root_reg);
    assign out_load = (state_reg == S_LINK) && can_load;

    assign edges.ready         = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_acc_reg;
    assign result.forest_edges = out_count_reg;

    always_comb
    begin
        mem_req.rd_addr = node_sel;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = cur_reg;
        mem_req.wr_data = root_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_reg;
                mem_req.wr_data = clr_reg;
            end
            S_WALK:
            begin
                mem_req.rd_addr = rd_data;
            end
            S_COMP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.rd_addr = rd_data;
            end
            S_LINK:
            begin
                mem_req.wr_en   = can_load && link_ok;
                mem_req.wr_addr = root_a_reg;
            end
            default:
            begin
                mem_req.rd_addr = node_sel;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            side_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == idx_t'(NODES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (edges.valid)
                    begin
                        node_a_reg <= idx_t'(edges.node_a);
                        node_b_reg <= idx_t'(edges.node_b);
                        skip_reg   <= !in_range;
                        side_reg   <= 1'b0;
                        state_reg  <= in_range ? S_WALK_RD : S_LINK;
                    end
                end
                S_WALK_RD:
                begin
                    cur_reg   <= node_sel;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (rd_data == cur_reg)
                    begin
                        root_reg <= cur_reg;
                        if (cur_reg != node_sel)
                        begin
                            state_reg <= S_COMP_RD;
                        end
                        else if (!side_reg)
                        begin
                            root_a_reg <= cur_reg;
                            side_reg   <= 1'b1;
                            state_reg  <= S_WALK_RD;
                        end
                        else
                        begin
                            state_reg <= S_LINK;
                        end
                    end
                    else
                    begin
                        cur_reg <= rd_data;
                    end
                end
                S_COMP_RD:
                begin
                    cur_reg   <= node_sel;
                    state_reg <= S_COMP;
                end
                S_COMP:
                begin
                    // the node just written pointed straight at the root: path done
                    if (rd_data == root_reg)
                    begin
                        if (!side_reg)
                        begin
                            root_a_reg <= root_reg;
                            side_reg   <= 1'b1;
                            state_reg  <= S_WALK_RD;
                        end
                        else
                        begin
                            state_reg <= S_LINK;
                        end
                    end
                    else
                    begin
                        cur_reg <= rd_data;
                    end
                end
                S_LINK:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_acc_reg   <= link_ok;
                        if (link_ok)
                        begin
                            count_reg     <= count_reg + 1'b1;
                            out_count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            out_count_reg <= count_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/ufsf_checker.sv */
`default_nettype none
module ufsf_checker
    import ufsf_pkg::*;
(
    input wire         clk,
    input wire         rst_n,
    input wire         in_valid,
    input wire         in_ready,
    input wire         out_valid,
    input wire         out_ready,
    input wire         out_accepted,
    input wire count_t out_forest_edges
);

    logic   in_xfer;
    logic   out_xfer;
    count_t last_count_reg;
    logic [1:0] pend_reg;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            if (out_xfer)
            begin
                last_count_reg <= out_forest_edges;
            end
            pend_reg <= pend_reg + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_accepted) && $stable(out_forest_edges))
        else $error("result payload changed while stalled");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> out_forest_edges == (out_accepted ? count_t'(last_count_reg + 1'b1)
                                                       : last_count_reg))
        else $error("forest edge count does not follow accepted flag");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> pend_reg != 2'd0)
        else $error("result transfer without a pending edge");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two edges outstanding");

endmodule

bind union_find_spanning_forest ufsf_checker u_ufsf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (edges.valid),
    .in_ready         (edges.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_accepted     (result.accepted),
    .out_forest_edges (result.forest_edges)
);
`default_nettype wire

/* test/union_find_spanning_forest_tb.sv */
module union_find_spanning_forest_tb;
    import ufsf_pkg::*;

    typedef struct {
        logic   accepted;
        count_t forest_edges;
    } edge_outcome_t;

    // keeps its own parent table and tree-edge count, queues one outcome per edge
    class forest_tracker;
        idx_t          parent[NODES];
        count_t        tree_edges;
        edge_outcome_t outstanding[$];
        int            mismatches;

        function new();
            foreach (parent[i])
                parent[i] = idx_t'(i);
            tree_edges = '0;
            mismatches = 0;
        endfunction

        function idx_t find_and_compress(idx_t node);
            idx_t root;
            idx_t cur;
            idx_t nxt;
            root = node;
            while (parent[root] != root)
                root = parent[root];
            cur = node;
            while (cur != root)
            begin
                nxt = parent[cur];
                parent[cur] = root;
                cur = nxt;
            end
            return root;
        endfunction

        function void note_edge(field_t a, field_t b);
            edge_outcome_t o;
            idx_t          ra;
            idx_t          rb;
            o.accepted = 1'b0;
            if (int'(a) < NODES && int'(b) < NODES)
            begin
                // path of node_a is compressed before the path of node_b
                ra = find_and_compress(idx_t'(a));
                rb = find_and_compress(idx_t'(b));
                if (ra != rb)
                begin
                    parent[ra] = rb;
                    tree_edges = tree_edges + 1'b1;
                    o.accepted = 1'b1;
                end
            end
            o.forest_edges = tree_edges;
            outstanding = {outstanding, o};
        endfunction

        function void check_result(logic acc, count_t fe);
            edge_outcome_t o;
            if (outstanding.size() == 0)
            begin
                $error("result transfer with no edge outstanding: accepted=%0d forest_edges=%0d",
                       acc, fe);
                mismatches++;
                return;
            end
            o = outstanding.pop_front();
            if (acc !== o.accepted)
            begin
                $error("accepted: expected %0d, actual %0d", o.accepted, acc);
                mismatches++;
            end
            if (fe !== o.forest_edges)
            begin
                $error("forest_edges: expected %0d, actual %0d", o.forest_edges, fe);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ufsf_edge_if   edges_if ();
    ufsf_result_if result_if ();

    union_find_spanning_forest dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .edges  (edges_if),
        .result (result_if)
    );

    forest_tracker tracker = new();

    int edges_sent  = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // sender side: bursts of random length, random gaps between them
    task automatic send_edge(input field_t a, input field_t b);
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            edges_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        edges_if.valid  = 1'b1;
        edges_if.node_a = a;
        edges_if.node_b = b;
        do
            @(posedge clk);
        while (!edges_if.ready);
        tracker.note_edge(a, b);
        edges_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // consecutive links build a fresh chain, then the ends close a cycle
    task automatic send_chain(input int len);
        field_t nodes[12];
        for (int i = 0; i < len; i++)
            nodes[i] = field_t'($urandom_range(0, NODES - 1));
        for (int i = 0; i + 1 < len; i++)
            send_edge(nodes[i], nodes[i+1]);
        send_edge(nodes[0], nodes[len-1]);
        if ($urandom_range(0, 1))
            send_edge(nodes[len-1], nodes[$urandom_range(0, len - 1)]);
    endtask

    function automatic field_t pick_extreme();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return field_t'($urandom_range(0, NODES - 1));
        endcase
    endfunction

    // receiver side: stall pattern switches between randomly chosen modes
    initial
    begin
        int stall_left;
        int mode;
        int mode_cycles;
        stall_left  = 0;
        mode        = 0;
        mode_cycles = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_cycles == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_cycles = $urandom_range(100, 400);
            end
            mode_cycles--;
            if (stall_left > 0)
            begin
                result_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready = 1'b1;
                if (mode == 1 && $urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 3);
                else if (mode == 2 && $urandom_range(0, 1) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            tracker.check_result(result_if.accepted, result_if.forest_edges);
    end

    initial
    begin
        int kind;
        field_t n;
        rst_n           = 1'b0;
        edges_if.valid  = 1'b0;
        edges_if.node_a = '0;
        edges_if.node_b = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // extremes, repeated edge, self loops, alternating bit patterns
        send_edge(10'd0, 10'd1023);
        send_edge(10'd1023, 10'd0);
        send_edge(10'd0, 10'd0);
        send_edge(10'd1023, 10'd1023);
        send_edge(10'd682, 10'd341);
        send_edge(10'd341, 10'd682);
        // chain 1 -> 2 -> ... -> 8, then a cycle edge that compresses the whole path
        for (int i = 1; i < 8; i++)
            send_edge(field_t'(i), field_t'(i + 1));
        send_edge(10'd1, 10'd8);
        send_edge(10'd2, 10'd9);
        send_edge(10'd9, 10'd0);
        send_edge(10'd4, 10'd682);
        send_edge(10'd1023, 10'd5);
        send_edge(10'd512, 10'd511);
        send_edge(10'd511, 10'd511);

        while (edges_sent < 750)
        begin
            if (edges_sent % 100 < 5)
                gaps_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind <= 3)
                send_chain($urandom_range(2, 10));
            else if (kind <= 5)
                send_edge(field_t'($urandom_range(0, 31)), field_t'($urandom_range(0, 31)));
            else if (kind <= 7)
                send_edge(field_t'($urandom_range(0, NODES - 1)),
                          field_t'($urandom_range(0, NODES - 1)));
            else if (kind == 8)
            begin
                n = field_t'($urandom_range(0, NODES - 1));
                send_edge(n, n);
            end
            else
                send_edge(pick_extreme(), pick_extreme());
        end

        @(negedge clk);
        edges_if.valid = 1'b0;
        while (tracker.outstanding.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
